/* hdl/tlvp_pkg.sv */
package tlvp_pkg;

   localparam int MSG_BYTES_DEF  = 256;
   localparam int NEST_DEPTH_DEF = 16;
   localparam int RESULT_CAP     = 20;
   // results one byte may cause before the closing nil
   localparam int POP_BUDGET     = RESULT_CAP - 1;
   localparam int CNT_W          = 5;
   localparam int END_W          = 10;
   localparam int CSR_IDX_W      = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TAG_SINT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAG_UINT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAG_TEXT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TAG_NEST = 2'd3;

   localparam logic [7:0] TAG_SINT_RST = 8'd1;
   localparam logic [7:0] TAG_UINT_RST = 8'd2;
   localparam logic [7:0] TAG_TEXT_RST = 8'd3;
   localparam logic [7:0] TAG_NEST_RST = 8'd4;

   localparam logic [1:0] PH_TAG = 2'd0;
   localparam logic [1:0] PH_LEN = 2'd1;
   localparam logic [1:0] PH_VAL = 2'd2;

   localparam logic [2:0] KIND_INT    = 3'd0;
   localparam logic [2:0] KIND_UINT   = 3'd1;
   localparam logic [2:0] KIND_TEXT   = 3'd2;
   localparam logic [2:0] KIND_STRUCT = 3'd3;
   localparam logic [2:0] KIND_END    = 3'd4;
   localparam logic [2:0] KIND_NIL    = 3'd5;
   localparam logic [2:0] KIND_OTHER  = 3'd6;

   typedef struct packed {
      logic [2:0]  token_kind;
      logic [7:0]  tag_seen;
      logic [7:0]  value_length;
      logic [31:0] int_value;
      logic [7:0]  char_byte;
      logic        char_valid;
      logic [7:0]  value_offset;
      logic        truncated;
      logic        nest_overflow;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic step;
      logic emit_tok;
      logic fetch;
      logic pop;
      logic emit_end;
      logic end_last;
      logic emit_nil;
   } cmd_type;

   typedef struct packed {
      logic tok_valid;
      logic pop_mode;
      logic fin;
      logic can_pop;
      logic out_free;
   } sts_type;

   // earlier registers win when several match
   function automatic logic [2:0] classify(input logic [7:0] tag, input logic [7:0] t_sint,
                                           input logic [7:0] t_uint, input logic [7:0] t_text,
                                           input logic [7:0] t_nest);
      logic [2:0] k;
      k = KIND_OTHER;
      if (tag == t_sint) k = KIND_INT;
      else if (tag == t_uint) k = KIND_UINT;
      else if (tag == t_text) k = KIND_TEXT;
      else if (tag == t_nest) k = KIND_STRUCT;
      return k;
   endfunction

endpackage

/* hdl/tlv_token_parser_top.sv */
// Streaming parser for nested tag-length-value messages.
// req_ channel: one message byte per transfer, req_final_byte on the last one.
// rsp_ channel: parsed results; rsp_last_of_run marks the last result caused
// by one input byte. Both channels use valid/stall. csr_ writes set the four
// tag codes; write them only while the parser is idle.
// A byte is worked in order: accept, then token. A tag byte or a final byte
// adds the stack check (top read, then compare), which repeats after each
// end-of-structure result; a final byte then adds the closing nil. A final
// byte past the message limit skips the stack check and gives only the nil.
// The stack memory's single registered read port sets the pop rate.
// A token result goes from the token register into the result register once
// the result register is free.
// req_stall is high while a byte is being worked; the result register is
// held and the controller waits while rsp_stall is high, so no result is lost.
// Reset (synchronous) restores the default tag codes, empties the structure
// stack and returns the parser to expect a tag at position 0; the same
// happens after every nil result except that the tag codes are kept.
module tlv_token_parser_top
   import tlvp_pkg::*;
#(
   parameter int MSG_BYTES  = MSG_BYTES_DEF,
   parameter int NEST_DEPTH = NEST_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_msg_byte,
   input  logic                 req_final_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_token_kind,
   output logic [7:0]           rsp_tag_seen,
   output logic [7:0]           rsp_value_length,
   output logic [31:0]          rsp_int_value,
   output logic [7:0]           rsp_char_byte,
   output logic                 rsp_char_valid,
   output logic [7:0]           rsp_value_offset,
   output logic                 rsp_truncated,
   output logic                 rsp_nest_overflow,
   output logic                 rsp_last_of_run,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   cmd_type cmd;
   sts_type sts;
   rsp_type rsp;

   tlvp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tlvp_datapath #(
      .MSG_BYTES  (MSG_BYTES),
      .NEST_DEPTH (NEST_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_msg_byte   (req_msg_byte),
      .req_final_byte (req_final_byte),
      .rsp_stall      (rsp_stall),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp            (rsp)
   );

   assign rsp_token_kind    = rsp.token_kind;
   assign rsp_tag_seen      = rsp.tag_seen;
   assign rsp_value_length  = rsp.value_length;
   assign rsp_int_value     = rsp.int_value;
   assign rsp_char_byte     = rsp.char_byte;
   assign rsp_char_valid    = rsp.char_valid;
   assign rsp_value_offset  = rsp.value_offset;
   assign rsp_truncated     = rsp.truncated;
   assign rsp_nest_overflow = rsp.nest_overflow;
   assign rsp_last_of_run   = rsp.last_of_run;

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.emit_tok, cmd.emit_end, cmd.emit_nil}))
      else $error("more than one result loaded in a cycle");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_tok || cmd.emit_end || cmd.emit_nil) |-> sts.out_free)
      else $error("result register overwritten while stalled");

   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> sts.can_pop)
      else $error("stack popped without a qualifying top entry");

   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> req_stall)
      else $error("new byte accepted while the previous one is in work");

endmodule

/* hdl/tlvp_datapath.sv */
module tlvp_datapath
   import tlvp_pkg::*;
#(
   parameter int MSG_BYTES  = MSG_BYTES_DEF,
   parameter int NEST_DEPTH = NEST_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata,
   input  logic [7:0]           req_msg_byte,
   input  logic                 req_final_byte,
   input  logic                 rsp_stall,
   input  cmd_type              cmd,
   output sts_type              sts,
   output logic                 rsp_valid,
   output rsp_type              rsp
);

   localparam int POS_W   = $clog2(MSG_BYTES + 1);
   localparam int DEPTH_W = $clog2(NEST_DEPTH + 1);
   localparam int AW      = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
   localparam logic [POS_W-1:0]   POS_LIMIT  = POS_W'(MSG_BYTES);
   localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(NEST_DEPTH);

   logic [7:0] tag_sint_ff, tag_uint_ff, tag_text_ff, tag_nest_ff;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [1:0]         phase_ff, phase_in;
   logic [7:0]         cur_tag_ff, cur_tag_in;
   logic [7:0]         remain_ff, remain_in;
   logic [31:0]        acc_ff, acc_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [7:0]         tok_len_ff, tok_len_in;
   logic [7:0]         tok_off_ff, tok_off_in;
   logic               fin_ff, fin_in;
   logic               trunc_ff, trunc_in;
   logic               pop_mode_ff, pop_mode_in;
   logic [POS_W-1:0]   thr_ff, thr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               tok_valid_ff, tok_valid_in;
   rsp_type            tok_ff, tok_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [END_W-1:0]   top_ff;

   logic [END_W-1:0]   stack_mem [NEST_DEPTH];

   logic [2:0]         kind;
   logic [7:0]         remain_dec;
   logic [31:0]        acc_shift;
   logic [POS_W-1:0]   pos_inc;
   logic               push;
   logic [END_W-1:0]   push_data;
   logic [AW-1:0]      rd_addr;
   logic               out_free;

   assign kind       = classify(cur_tag_ff, tag_sint_ff, tag_uint_ff, tag_text_ff, tag_nest_ff);
   assign remain_dec = (remain_ff != 8'd0) ? remain_ff - 8'd1 : 8'd0;
   assign acc_shift  = {acc_ff[23:0], req_msg_byte};
   assign pos_inc    = pos_ff + POS_W'(1);
   assign push_data  = END_W'(pos_inc) + END_W'(req_msg_byte);
   assign rd_addr    = (depth_ff == '0) ? '0 : AW'(depth_ff - DEPTH_W'(1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      cur_tag_in   = cur_tag_ff;
      remain_in    = remain_ff;
      acc_in       = acc_ff;
      depth_in     = depth_ff;
      tok_len_in   = tok_len_ff;
      tok_off_in   = tok_off_ff;
      fin_in       = fin_ff;
      trunc_in     = trunc_ff;
      pop_mode_in  = pop_mode_ff;
      thr_in       = thr_ff;
      cnt_in       = cnt_ff;
      tok_valid_in = tok_valid_ff;
      tok_in       = tok_ff;
      push         = 1'b0;
      if (cmd.step) begin
         fin_in       = req_final_byte;
         tok_valid_in = 1'b0;
         tok_in       = '0;
         tok_in.last_of_run = !req_final_byte;
         pop_mode_in  = 1'b0;
         thr_in       = pos_inc;
         if (pos_ff >= POS_LIMIT) begin
            trunc_in = 1'b1;
         end else begin
            pos_in = pos_inc;
            case (phase_ff)
               PH_TAG: begin
                  cur_tag_in  = req_msg_byte;
                  phase_in    = PH_LEN;
                  pop_mode_in = 1'b1;
                  if (!req_final_byte) thr_in = pos_ff;
               end
               PH_LEN: begin
                  tok_len_in          = req_msg_byte;
                  tok_off_in          = 8'(pos_inc);
                  acc_in              = '0;
                  remain_in           = req_msg_byte;
                  phase_in            = (req_msg_byte != 8'd0) ? PH_VAL : PH_TAG;
                  pop_mode_in         = req_final_byte;
                  tok_in.tag_seen     = cur_tag_ff;
                  tok_in.value_length = req_msg_byte;
                  tok_in.value_offset = 8'(pos_inc);
                  tok_in.token_kind   = kind;
                  case (kind)
                     KIND_INT, KIND_UINT: begin
                        tok_valid_in = (req_msg_byte == 8'd0);
                     end
                     KIND_TEXT: begin
                        tok_valid_in = 1'b1;
                     end
                     KIND_STRUCT: begin
                        tok_valid_in = 1'b1;
                        remain_in    = '0;
                        phase_in     = PH_TAG;
                        if (depth_ff < DEPTH_FULL) begin
                           push     = 1'b1;
                           depth_in = depth_ff + DEPTH_W'(1);
                        end else begin
                           tok_in.nest_overflow = 1'b1;
                        end
                     end
                     default: begin
                        tok_valid_in      = 1'b1;
                        tok_in.token_kind = KIND_OTHER;
                     end
                  endcase
               end
               default: begin
                  remain_in           = remain_dec;
                  pop_mode_in         = req_final_byte;
                  tok_in.token_kind   = kind;
                  tok_in.tag_seen     = cur_tag_ff;
                  tok_in.value_length = tok_len_ff;
                  tok_in.value_offset = tok_off_ff;
                  if (kind == KIND_INT || kind == KIND_UINT) begin
                     acc_in           = acc_shift;
                     tok_in.int_value = acc_shift;
                     tok_valid_in     = (remain_dec == 8'd0);
                  end else if (kind == KIND_TEXT) begin
                     tok_in.char_byte  = req_msg_byte;
                     tok_in.char_valid = 1'b1;
                     tok_valid_in      = 1'b1;
                  end
                  if (remain_dec == 8'd0) phase_in = PH_TAG;
               end
            endcase
            trunc_in = (phase_in != PH_TAG);
         end
         cnt_in = tok_valid_in ? CNT_W'(1) : '0;
      end
      if (cmd.pop) begin
         depth_in = depth_ff - DEPTH_W'(1);
         cnt_in   = cnt_ff + CNT_W'(1);
      end
      if (cmd.emit_nil) begin
         pos_in     = '0;
         phase_in   = PH_TAG;
         cur_tag_in = '0;
         remain_in  = '0;
         acc_in     = '0;
         depth_in   = '0;
         tok_len_in = '0;
         tok_off_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (cmd.emit_tok) begin
         rsp_valid_in = 1'b1;
         rsp_in       = tok_ff;
      end else if (cmd.emit_end) begin
         rsp_valid_in       = 1'b1;
         rsp_in             = '0;
         rsp_in.token_kind  = KIND_END;
         rsp_in.last_of_run = cmd.end_last;
      end else if (cmd.emit_nil) begin
         rsp_valid_in       = 1'b1;
         rsp_in             = '0;
         rsp_in.token_kind  = KIND_NIL;
         rsp_in.truncated   = trunc_ff;
         rsp_in.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_sint_ff  <= TAG_SINT_RST;
         tag_uint_ff  <= TAG_UINT_RST;
         tag_text_ff  <= TAG_TEXT_RST;
         tag_nest_ff  <= TAG_NEST_RST;
         pos_ff       <= '0;
         phase_ff     <= PH_TAG;
         cur_tag_ff   <= '0;
         remain_ff    <= '0;
         acc_ff       <= '0;
         depth_ff     <= '0;
         tok_len_ff   <= '0;
         tok_off_ff   <= '0;
         fin_ff       <= 1'b0;
         trunc_ff     <= 1'b0;
         pop_mode_ff  <= 1'b0;
         thr_ff       <= '0;
         cnt_ff       <= '0;
         tok_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_TAG_SINT: tag_sint_ff <= csr_wdata;
               CSR_TAG_UINT: tag_uint_ff <= csr_wdata;
               CSR_TAG_TEXT: tag_text_ff <= csr_wdata;
               CSR_TAG_NEST: tag_nest_ff <= csr_wdata;
               default: ;
            endcase
         end
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         cur_tag_ff   <= cur_tag_in;
         remain_ff    <= remain_in;
         acc_ff       <= acc_in;
         depth_ff     <= depth_in;
         tok_len_ff   <= tok_len_in;
         tok_off_ff   <= tok_off_in;
         fin_ff       <= fin_in;
         trunc_ff     <= trunc_in;
         pop_mode_ff  <= pop_mode_in;
         thr_ff       <= thr_in;
         cnt_ff       <= cnt_in;
         tok_valid_ff <= tok_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      rsp_ff <= rsp_in;
   end

   // end-position stack: one write port, one registered read of the top entry
   always_ff @(posedge clock) begin
      if (push) stack_mem[depth_ff[AW-1:0]] <= push_data;
      if (cmd.fetch) top_ff <= stack_mem[rd_addr];
   end

   assign sts.tok_valid = tok_valid_ff;
   assign sts.pop_mode  = pop_mode_ff;
   assign sts.fin       = fin_ff;
   assign sts.can_pop   = (depth_ff != '0) && (cnt_ff < CNT_W'(POP_BUDGET)) &&
                          (top_ff <= END_W'(thr_ff));
   assign sts.out_free  = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* hdl/tlvp_ctrl.sv */
module tlvp_ctrl
   import tlvp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_TOKEN = 3'd1;
   localparam logic [2:0] ST_FETCH = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_NIL   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       pend_ff, pend_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      pend_in  = pend_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.step = 1'b1;
               state_in = ST_TOKEN;
            end
         end
         ST_TOKEN: begin
            if (!sts.tok_valid || sts.out_free) begin
               cmd.emit_tok = sts.tok_valid;
               if (sts.pop_mode) state_in = ST_FETCH;
               else if (sts.fin) state_in = ST_NIL;
               else state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            // a popped end result waits here until the next top is known
            if (!pend_ff || sts.out_free) begin
               cmd.emit_end = pend_ff;
               cmd.end_last = !sts.can_pop && !sts.fin;
               pend_in      = 1'b0;
               if (sts.can_pop) begin
                  cmd.pop  = 1'b1;
                  pend_in  = 1'b1;
                  state_in = ST_FETCH;
               end else if (sts.fin) begin
                  state_in = ST_NIL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_NIL: begin
            if (sts.out_free) begin
               cmd.emit_nil = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

/* verif/testbench.sv */
module testbench;
   import tlvp_pkg::*;

   localparam int RANDOM_ITEMS   = 410;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 50;

   localparam int SHAPE_PLAIN = 0;
   localparam int SHAPE_DEEP  = 1;
   localparam int SHAPE_NOISE = 2;
   localparam int SHAPE_LONG  = 3;

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } msg_item_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_msg_byte = 8'd0;
   logic                 req_final_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [2:0]           rsp_token_kind;
   logic [7:0]           rsp_tag_seen;
   logic [7:0]           rsp_value_length;
   logic [31:0]          rsp_int_value;
   logic [7:0]           rsp_char_byte;
   logic                 rsp_char_valid;
   logic [7:0]           rsp_value_offset;
   logic                 rsp_truncated;
   logic                 rsp_nest_overflow;
   logic                 rsp_last_of_run;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]           csr_wdata = 8'd0;

   tlv_token_parser_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_msg_byte      (req_msg_byte),
      .req_final_byte    (req_final_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_tag_seen      (rsp_tag_seen),
      .rsp_value_length  (rsp_value_length),
      .rsp_int_value     (rsp_int_value),
      .rsp_char_byte     (rsp_char_byte),
      .rsp_char_valid    (rsp_char_valid),
      .rsp_value_offset  (rsp_value_offset),
      .rsp_truncated     (rsp_truncated),
      .rsp_nest_overflow (rsp_nest_overflow),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // parser state as the testbench sees it
   logic [7:0]  cfg_tag [4];
   logic [8:0]  pos_q;
   logic [1:0]  phase_q;
   logic [7:0]  tag_q;
   logic [7:0]  left_q;
   logic [7:0]  len_q;
   logic [8:0]  off_q;
   logic [31:0] acc_q;
   logic [9:0]  nest_ends [NEST_DEPTH_DEF];
   int          depth_q;

   rsp_type      byte_tokens[$];
   rsp_type      expected_tokens[$];
   msg_item_type tx_bytes[$];
   msg_item_type carry_q[$];
   logic [7:0]   msg_buf[$];

   int          mismatch_cnt = 0;
   int          send_gap = 0;
   int          stall_left = 0;
   int          idle_cycles = 0;
   bit          calm = 1'b0;

   function automatic void restart_parse();
      pos_q   = '0;
      phase_q = PH_TAG;
      tag_q   = '0;
      left_q  = '0;
      len_q   = '0;
      off_q   = '0;
      acc_q   = '0;
      depth_q = 0;
   endfunction

   function automatic logic [2:0] tag_kind(logic [7:0] t);
      if (t == cfg_tag[CSR_TAG_SINT]) return KIND_INT;
      if (t == cfg_tag[CSR_TAG_UINT]) return KIND_UINT;
      if (t == cfg_tag[CSR_TAG_TEXT]) return KIND_TEXT;
      if (t == cfg_tag[CSR_TAG_NEST]) return KIND_STRUCT;
      return KIND_OTHER;
   endfunction

   function automatic void add_token(logic [2:0] kind, logic [7:0] tag, logic [7:0] len,
                                     logic [31:0] val, logic [7:0] ch, logic cv,
                                     logic [7:0] off, logic tr, logic ov);
      rsp_type r;
      r.token_kind    = kind;
      r.tag_seen      = tag;
      r.value_length  = len;
      r.int_value     = val;
      r.char_byte     = ch;
      r.char_valid    = cv;
      r.value_offset  = off;
      r.truncated     = tr;
      r.nest_overflow = ov;
      r.last_of_run   = 1'b0;
      byte_tokens.push_back(r);
   endfunction

   // close every structure whose end lies at or before this position, up to the pop budget
   function automatic void pop_structs(logic [8:0] p);
      while (depth_q > 0 && byte_tokens.size() < POP_BUDGET &&
             {1'b0, p} >= nest_ends[depth_q - 1]) begin
         depth_q--;
         add_token(KIND_END, 8'd0, 8'd0, 32'd0, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0);
      end
   endfunction

   function automatic void predict_tokens(logic [7:0] data, logic fin);
      logic [2:0] kind;
      logic [8:0] p;
      logic       ovf;
      logic       tr;
      rsp_type    r;
      byte_tokens.delete();
      if (pos_q >= 9'(MSG_BYTES_DEF)) begin
         if (fin) begin
            add_token(KIND_NIL, 8'd0, 8'd0, 32'd0, 8'd0, 1'b0, 8'd0, 1'b1, 1'b0);
            restart_parse();
         end
      end else begin
         p = pos_q;
         if (phase_q == PH_TAG) begin
            pop_structs(p);
            tag_q   = data;
            phase_q = PH_LEN;
         end else if (phase_q == PH_LEN) begin
            kind    = tag_kind(tag_q);
            len_q   = data;
            off_q   = p + 9'd1;
            acc_q   = '0;
            left_q  = data;
            phase_q = (data != 8'd0) ? PH_VAL : PH_TAG;
            if (kind == KIND_INT || kind == KIND_UINT) begin
               if (data == 8'd0)
                  add_token(kind, tag_q, 8'd0, 32'd0, 8'd0, 1'b0, off_q[7:0], 1'b0, 1'b0);
            end else if (kind == KIND_TEXT) begin
               add_token(KIND_TEXT, tag_q, data, 32'd0, 8'd0, 1'b0, off_q[7:0], 1'b0, 1'b0);
            end else if (kind == KIND_STRUCT) begin
               ovf = (depth_q >= NEST_DEPTH_DEF);
               if (!ovf) begin
                  nest_ends[depth_q] = {1'b0, p} + {2'b0, data} + 10'd1;
                  depth_q++;
               end
               add_token(KIND_STRUCT, tag_q, data, 32'd0, 8'd0, 1'b0, off_q[7:0], 1'b0, ovf);
               left_q  = '0;
               phase_q = PH_TAG;
            end else begin
               add_token(KIND_OTHER, tag_q, data, 32'd0, 8'd0, 1'b0, off_q[7:0], 1'b0, 1'b0);
            end
         end else begin
            kind = tag_kind(tag_q);
            if (left_q != 8'd0) left_q--;
            if (kind == KIND_INT || kind == KIND_UINT) begin
               acc_q = {acc_q[23:0], data};
               if (left_q == 8'd0)
                  add_token(kind, tag_q, len_q, acc_q, 8'd0, 1'b0, off_q[7:0], 1'b0, 1'b0);
            end else if (kind == KIND_TEXT) begin
               add_token(KIND_TEXT, tag_q, len_q, 32'd0, data, 1'b1, off_q[7:0], 1'b0, 1'b0);
            end
            if (left_q == 8'd0) phase_q = PH_TAG;
         end
         pos_q = p + 9'd1;
         if (fin) begin
            tr = (phase_q != PH_TAG);
            pop_structs(pos_q);
            add_token(KIND_NIL, 8'd0, 8'd0, 32'd0, 8'd0, 1'b0, 8'd0, tr, 1'b0);
            restart_parse();
         end
      end
      for (int i = 0; i < byte_tokens.size(); i++) begin
         r = byte_tokens[i];
         r.last_of_run = (i == byte_tokens.size() - 1);
         expected_tokens.push_back(r);
      end
   endfunction

   function automatic bit same_token(rsp_type a, rsp_type b);
      return a.token_kind === b.token_kind && a.tag_seen === b.tag_seen &&
             a.value_length === b.value_length && a.int_value === b.int_value &&
             a.char_byte === b.char_byte && a.char_valid === b.char_valid &&
             a.value_offset === b.value_offset && a.truncated === b.truncated &&
             a.nest_overflow === b.nest_overflow && a.last_of_run === b.last_of_run;
   endfunction

   function automatic string fmt_token(rsp_type r);
      return $sformatf("kind %0d tag %h len %0d int %h char %h/%b off %0d trunc %b ovf %b last %b",
                       r.token_kind, r.tag_seen, r.value_length, r.int_value, r.char_byte,
                       r.char_valid, r.value_offset, r.truncated, r.nest_overflow,
                       r.last_of_run);
   endfunction

   function automatic void check_token();
      rsp_type got;
      rsp_type want;
      got.token_kind    = rsp_token_kind;
      got.tag_seen      = rsp_tag_seen;
      got.value_length  = rsp_value_length;
      got.int_value     = rsp_int_value;
      got.char_byte     = rsp_char_byte;
      got.char_valid    = rsp_char_valid;
      got.value_offset  = rsp_value_offset;
      got.truncated     = rsp_truncated;
      got.nest_overflow = rsp_nest_overflow;
      got.last_of_run   = rsp_last_of_run;
      if (expected_tokens.size() == 0) begin
         mismatch_cnt++;
         if (mismatch_cnt <= 10) $display("unexpected result: %s", fmt_token(got));
      end else begin
         want = expected_tokens[0];
         expected_tokens.delete(0);
         if (!same_token(want, got)) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
               $display("result mismatch at %0t", $realtime);
               $display("   expected %s", fmt_token(want));
               $display("   actual   %s", fmt_token(got));
            end
         end
      end
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_tokens(req_msg_byte, req_final_byte);
            tx_bytes.delete(0);
            send_gap = pick_gap();
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (tx_bytes.size() > 0) begin
               req_valid      <= 1'b1;
               req_msg_byte   <= tx_bytes[0].data;
               req_final_byte <= tx_bytes[0].fin;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_token();
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic void add_element(int lvl);
      int         pick;
      int         start;
      int         n;
      logic [7:0] len;
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         msg_buf.push_back(cfg_tag[$urandom_range(0, 1)]);
         len = 8'($urandom_range(0, 6));
         msg_buf.push_back(len);
         repeat (len) msg_buf.push_back(8'($urandom));
      end else if (pick < 6) begin
         msg_buf.push_back(cfg_tag[CSR_TAG_TEXT]);
         len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(8, 40))
                                           : 8'($urandom_range(0, 6));
         msg_buf.push_back(len);
         repeat (len) msg_buf.push_back(8'($urandom));
      end else if (pick < 8 && lvl < 3) begin
         msg_buf.push_back(cfg_tag[CSR_TAG_NEST]);
         msg_buf.push_back(8'd0);
         start = msg_buf.size();
         n = $urandom_range(0, 3);
         repeat (n) add_element(lvl + 1);
         n = msg_buf.size() - start;
         // now and then a structure length that does not match its content
         if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 255);
         msg_buf[start - 1] = 8'((n > 255) ? 255 : n);
      end else begin
         msg_buf.push_back(8'($urandom));
         len = 8'($urandom_range(0, 4));
         msg_buf.push_back(len);
         repeat (len) msg_buf.push_back(8'($urandom));
      end
   endfunction

   // a stack of structures that all end at the same byte, past the stack depth at times
   function automatic void build_deep_nest();
      int starts[$];
      int d;
      d = $urandom_range(12, 18);
      repeat (d) begin
         msg_buf.push_back(cfg_tag[CSR_TAG_NEST]);
         msg_buf.push_back(8'd0);
         starts.push_back(msg_buf.size());
      end
      add_element(3);
      foreach (starts[i]) msg_buf[starts[i] - 1] = 8'(msg_buf.size() - starts[i]);
      add_element(3);
   endfunction

   function automatic void build_message(int shape);
      int n;
      msg_buf.delete();
      case (shape)
         SHAPE_DEEP: build_deep_nest();
         SHAPE_NOISE: repeat ($urandom_range(1, 8)) msg_buf.push_back(8'($urandom));
         SHAPE_LONG: begin
            msg_buf.push_back(cfg_tag[CSR_TAG_NEST]);
            msg_buf.push_back(8'd255);
            msg_buf.push_back(cfg_tag[CSR_TAG_TEXT]);
            msg_buf.push_back(8'd180);
            repeat (180) msg_buf.push_back(8'($urandom));
            while (msg_buf.size() < 262) add_element(1);
         end
         default: repeat ($urandom_range(1, 5)) add_element(0);
      endcase
      // cut some messages short so the final byte lands inside an element
      if (shape != SHAPE_LONG && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, msg_buf.size());
         while (msg_buf.size() > n) msg_buf.delete(msg_buf.size() - 1);
      end
   endfunction

   function automatic int pick_shape();
      int r;
      r = $urandom_range(0, 19);
      if (r < 15) return SHAPE_PLAIN;
      if (r < 17) return SHAPE_DEEP;
      return SHAPE_NOISE;
   endfunction

   // bytes past keep wait for the next register setting
   function automatic void queue_message(int keep);
      msg_item_type it;
      for (int i = 0; i < msg_buf.size(); i++) begin
         it.data = msg_buf[i];
         it.fin  = (i == msg_buf.size() - 1);
         if (i < keep) tx_bytes.push_back(it);
         else carry_q.push_back(it);
      end
   endfunction

   task automatic wait_idle(int settle);
      while (tx_bytes.size() != 0 || req_valid || expected_tokens.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_tag(logic [CSR_IDX_W-1:0] idx, logic [7:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_tag[idx] = val;
   endtask

   task automatic load_tags(int ph);
      logic [7:0] v [4];
      case (ph % 7)
         0: foreach (v[i]) v[i] = 8'($urandom);
         1: v = '{8'h00, 8'hFF, 8'h80, 8'h7F};
         2: v = '{TAG_SINT_RST, TAG_UINT_RST, TAG_TEXT_RST, TAG_NEST_RST};
         3: v = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
         4: v = '{8'h00, 8'h00, 8'h00, 8'h00};
         5: begin
            v[0] = 8'($urandom);
            v[1] = v[0];
            v[2] = v[0];
            v[3] = v[0];
         end
         default: begin
            foreach (v[i]) v[i] = 8'($urandom);
            v[3] = v[2];
         end
      endcase
      write_tag(CSR_TAG_SINT, v[0]);
      write_tag(CSR_TAG_UINT, v[1]);
      write_tag(CSR_TAG_TEXT, v[2]);
      write_tag(CSR_TAG_NEST, v[3]);
   endtask

   initial begin
      int random_cnt;
      int phase_no;
      int phase_len;
      int phase_goal;
      int keep;
      random_cnt = 0;
      phase_no   = 0;
      cfg_tag = '{TAG_SINT_RST, TAG_UINT_RST, TAG_TEXT_RST, TAG_NEST_RST};
      restart_parse();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty and full-width integers, a wrapping one, empty text, a structure
      // closed by the next tag, an unknown tag, then a text cut short
      msg_buf = '{TAG_SINT_RST, 8'h00,
                  TAG_SINT_RST, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  TAG_UINT_RST, 8'h05, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
                  TAG_TEXT_RST, 8'h00,
                  TAG_NEST_RST, 8'h03, TAG_TEXT_RST, 8'h01, 8'h41,
                  8'hEE, 8'h01, 8'h00,
                  TAG_TEXT_RST, 8'h02, 8'hFF};
      queue_message(msg_buf.size());
      // message of a single byte
      msg_buf = '{8'h00};
      queue_message(msg_buf.size());

      while (random_cnt < RANDOM_ITEMS) begin
         wait_idle(40);
         load_tags(phase_no);
         calm = ($urandom_range(0, 3) == 0);
         foreach (carry_q[i]) tx_bytes.push_back(carry_q[i]);
         carry_q.delete();
         phase_len  = 0;
         phase_goal = $urandom_range(30, 70);
         if (phase_no == 2) begin
            build_message(SHAPE_LONG);
            queue_message(msg_buf.size());
            phase_len += msg_buf.size();
         end
         while (phase_len < phase_goal) begin
            build_message(pick_shape());
            keep = msg_buf.size();
            if (phase_len + keep >= phase_goal && $urandom_range(0, 1) == 1)
               keep = $urandom_range(1, msg_buf.size());
            queue_message(keep);
            phase_len += msg_buf.size();
         end
         random_cnt += phase_len;
         phase_no++;
      end
      foreach (carry_q[i]) tx_bytes.push_back(carry_q[i]);
      carry_q.delete();

      wait_idle(SETTLE_CYCLES);
      if (mismatch_cnt == 0 && expected_tokens.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
